>>> rtl/core/ctpg_pkg.sv
// ----------------------------------------------------------------------------
// ctpg_pkg
// Shared types and constants of the countdown thermostat pump gate.
// ----------------------------------------------------------------------------
package ctpg_pkg;

  localparam int unsigned AdcWidthDef = 10;
  localparam int unsigned CfgIdxW     = 3;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_TICK  = 2'd1,
    OP_TEMP  = 2'd2,
    OP_ADC   = 2'd3
  } opcode_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_TEMP_LIMIT  = 3'd0,
    REG_PRESCALE    = 3'd1,
    REG_PRESET_HRS  = 3'd2,
    REG_PRESET_MIN  = 3'd3,
    REG_PRESET_SEC  = 3'd4
  } reg_idx_e;

  localparam logic [7:0] PRESCALE_RST = 8'd31;
  localparam logic [7:0] TEMP_NEG_MAX = 8'd127;
  localparam logic [5:0] SEC_LAST     = 6'd59;
  localparam logic [5:0] MIN_LAST     = 6'd59;
  localparam logic [4:0] HOURS_WRAP   = 5'd24;
  localparam logic [5:0] SIXTY_WRAP   = 6'd60;

  typedef struct packed {
    logic [7:0] temp_limit;
    logic [7:0] prescale_count;
    logic [4:0] preset_hours;
    logic [5:0] preset_minutes;
    logic [5:0] preset_seconds;
  } cfg_t;

  typedef struct packed {
    opcode_e    opcode;
    logic [7:0] temperature;
  } evt_ctl_t;

endpackage

>>> rtl/core/ctpg_intf.sv
// ----------------------------------------------------------------------------
// ctpg interfaces
// Event, result and configuration channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface ctpg_evt_if #(
  parameter int unsigned ADC_WIDTH = ctpg_pkg::AdcWidthDef
);
  logic                 valid;
  logic                 ready;
  logic [1:0]           opcode;
  logic [7:0]           temperature;
  logic [ADC_WIDTH-1:0] adc_sample;

  modport source (output valid, opcode, temperature, adc_sample, input ready);
  modport sink   (input valid, opcode, temperature, adc_sample, output ready);
endinterface

interface ctpg_res_if #(
  parameter int unsigned ADC_WIDTH = ctpg_pkg::AdcWidthDef
);
  logic                 valid;
  logic                 ready;
  logic [ADC_WIDTH-1:0] pump_drive;
  logic                 pump_on;
  logic                 running;
  logic                 finished;
  logic [4:0]           hours_left;
  logic [5:0]           minutes_left;
  logic [5:0]           seconds_left;

  modport source (output valid, pump_drive, pump_on, running, finished,
                  hours_left, minutes_left, seconds_left, input ready);
  modport sink   (input valid, pump_drive, pump_on, running, finished,
                  hours_left, minutes_left, seconds_left, output ready);
endinterface

interface ctpg_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [ctpg_pkg::CfgIdxW-1:0] index;
  logic [7:0]                   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/core/ctpg_cfg_regs.sv
// ----------------------------------------------------------------------------
// ctpg_cfg_regs
// Configuration register file: threshold, prescaler and preset time.
// ----------------------------------------------------------------------------
module ctpg_cfg_regs (
  input  logic           clk_i,
  input  logic           rst_ni,
  ctpg_cfg_if.sink       cfg_i,
  output ctpg_pkg::cfg_t cfg_o
);

  ctpg_pkg::cfg_t cfg_q;

  assign cfg_i.ready = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.temp_limit     <= '0;
      cfg_q.prescale_count <= ctpg_pkg::PRESCALE_RST;
      cfg_q.preset_hours   <= '0;
      cfg_q.preset_minutes <= '0;
      cfg_q.preset_seconds <= '0;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        ctpg_pkg::REG_TEMP_LIMIT: cfg_q.temp_limit     <= cfg_i.data;
        ctpg_pkg::REG_PRESCALE:   cfg_q.prescale_count <= cfg_i.data;
        ctpg_pkg::REG_PRESET_HRS: cfg_q.preset_hours   <= cfg_i.data[4:0];
        ctpg_pkg::REG_PRESET_MIN: cfg_q.preset_minutes <= cfg_i.data[5:0];
        ctpg_pkg::REG_PRESET_SEC: cfg_q.preset_seconds <= cfg_i.data[5:0];
        default: ;
      endcase
    end
  end

endmodule

>>> rtl/core/ctpg_in_stage.sv
// ----------------------------------------------------------------------------
// ctpg_in_stage
// Input register for event beats, refilled in the cycle it drains.
// ----------------------------------------------------------------------------
module ctpg_in_stage #(
  parameter int unsigned ADC_WIDTH = ctpg_pkg::AdcWidthDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  ctpg_evt_if.sink             evt_i,
  input  logic                 take_i,
  output logic                 valid_o,
  output ctpg_pkg::evt_ctl_t   ctl_o,
  output logic [ADC_WIDTH-1:0] sample_o
);

  logic                 valid_q;
  ctpg_pkg::evt_ctl_t   ctl_q;
  logic [ADC_WIDTH-1:0] sample_q;
  logic                 load;

  assign evt_i.ready = !valid_q || take_i;
  assign load        = evt_i.valid && evt_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= 1'b1;
    end else if (take_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      ctl_q.opcode      <= ctpg_pkg::opcode_e'(evt_i.opcode);
      ctl_q.temperature <= evt_i.temperature;
      sample_q          <= evt_i.adc_sample;
    end
  end

  assign valid_o  = valid_q;
  assign ctl_o    = ctl_q;
  assign sample_o = sample_q;

  // a held beat must not change under a stalled core
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && !take_i |=> valid_q && $stable(ctl_q) && $stable(sample_q))
    else $error("held event beat changed");

endmodule

>>> rtl/core/ctpg_core.sv
// ----------------------------------------------------------------------------
// ctpg_core
// Countdown, prescaler, thermostat and drive gate with the result register.
// ----------------------------------------------------------------------------
module ctpg_core #(
  parameter int unsigned ADC_WIDTH = ctpg_pkg::AdcWidthDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ctpg_pkg::cfg_t       cfg_i,
  input  logic                 valid_i,
  input  ctpg_pkg::evt_ctl_t   ctl_i,
  input  logic [ADC_WIDTH-1:0] sample_i,
  output logic                 take_o,
  ctpg_res_if.source           res_o
);

  logic [7:0] div_q, div_d, div_inc;
  logic [4:0] hrs_q, hrs_d;
  logic [5:0] min_q, min_d;
  logic [5:0] sec_q, sec_d;
  logic       run_q, run_d;
  logic       pump_q, pump_d;

  logic                 res_valid_q;
  logic                 done_q, done_d;
  logic [ADC_WIDTH-1:0] drive_q, drive_d;

  assign take_o  = valid_i && (!res_valid_q || res_o.ready);
  assign div_inc = div_q + 8'd1;

  always_comb begin
    div_d   = div_q;
    hrs_d   = hrs_q;
    min_d   = min_q;
    sec_d   = sec_q;
    run_d   = run_q;
    pump_d  = pump_q;
    done_d  = 1'b0;
    drive_d = '0;
    case (ctl_i.opcode)
      ctpg_pkg::OP_START: begin
        div_d  = '0;
        hrs_d  = (cfg_i.preset_hours >= ctpg_pkg::HOURS_WRAP) ?
                 cfg_i.preset_hours - ctpg_pkg::HOURS_WRAP : cfg_i.preset_hours;
        min_d  = (cfg_i.preset_minutes >= ctpg_pkg::SIXTY_WRAP) ?
                 cfg_i.preset_minutes - ctpg_pkg::SIXTY_WRAP : cfg_i.preset_minutes;
        sec_d  = (cfg_i.preset_seconds >= ctpg_pkg::SIXTY_WRAP) ?
                 cfg_i.preset_seconds - ctpg_pkg::SIXTY_WRAP : cfg_i.preset_seconds;
        run_d  = 1'b1;
        pump_d = 1'b1;
      end
      ctpg_pkg::OP_TICK: begin
        if (run_q) begin
          if (div_inc == cfg_i.prescale_count) begin
            div_d = '0;
            // one second down, borrowing from minutes then hours
            if (sec_q != 6'd0) begin
              sec_d = sec_q - 6'd1;
            end else if (min_q != 6'd0) begin
              min_d = min_q - 6'd1;
              sec_d = ctpg_pkg::SEC_LAST;
            end else if (hrs_q != 5'd0) begin
              hrs_d = hrs_q - 5'd1;
              min_d = ctpg_pkg::MIN_LAST;
              sec_d = ctpg_pkg::SEC_LAST;
            end else begin
              run_d  = 1'b0;
              pump_d = 1'b0;
              done_d = 1'b1;
            end
          end else begin
            div_d = div_inc;
          end
        end
      end
      ctpg_pkg::OP_TEMP: begin
        if (ctl_i.temperature > ctpg_pkg::TEMP_NEG_MAX) begin
          pump_d = 1'b0;
        end else if (ctl_i.temperature > cfg_i.temp_limit) begin
          pump_d = 1'b1;
        end else if (ctl_i.temperature < cfg_i.temp_limit) begin
          pump_d = 1'b0;
        end
      end
      ctpg_pkg::OP_ADC: begin
        if (run_q && pump_q) begin
          drive_d = sample_i;
        end
      end
      default: ;
    endcase
  end

  // state only moves when a result beat is produced, so it always matches
  // the result currently shown
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_q       <= '0;
      hrs_q       <= '0;
      min_q       <= '0;
      sec_q       <= '0;
      run_q       <= 1'b0;
      pump_q      <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      if (take_o) begin
        div_q  <= div_d;
        hrs_q  <= hrs_d;
        min_q  <= min_d;
        sec_q  <= sec_d;
        run_q  <= run_d;
        pump_q <= pump_d;
      end
      if (take_o) begin
        res_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o) begin
      done_q  <= done_d;
      drive_q <= drive_d;
    end
  end

  assign res_o.valid        = res_valid_q;
  assign res_o.pump_drive   = drive_q;
  assign res_o.pump_on      = pump_q;
  assign res_o.running      = run_q;
  assign res_o.finished     = done_q;
  assign res_o.hours_left   = hrs_q;
  assign res_o.minutes_left = min_q;
  assign res_o.seconds_left = sec_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && done_q |-> !run_q && !pump_q &&
      hrs_q == 5'd0 && min_q == 6'd0 && sec_q == 6'd0)
    else $error("finished beat with live run or nonzero time");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && drive_q != '0 |-> run_q && pump_q)
    else $error("pump drive without running pump");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    sec_q <= ctpg_pkg::SEC_LAST && min_q <= ctpg_pkg::MIN_LAST &&
      hrs_q < ctpg_pkg::HOURS_WRAP)
    else $error("countdown time out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_o && ctl_i.opcode == ctpg_pkg::OP_START |=> run_q && pump_q && div_q == 8'd0)
    else $error("start did not begin a run");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !take_o |=> $stable(run_q) && $stable(pump_q) && $stable(div_q) && $stable(sec_q))
    else $error("state moved without an event");

endmodule

>>> rtl/core/countdown_thermostat_pump_gate.sv
// ----------------------------------------------------------------------------
// countdown_thermostat_pump_gate
// Countdown timer with prescaler, thermostat pump flag and gated pump drive.
// ----------------------------------------------------------------------------
// path: an accepted event beat is held in the input register, then in the core's result registers
// throughput: one event per cycle while the result side accepts, set by the input
//   register and the single state update per cycle in the core
// reset: rst_ni asynchronous, active low; clears countdown, prescaler, run and pump
//   flags and valids, config resets to prescale 31 and zero for all else
module countdown_thermostat_pump_gate #(
  parameter int unsigned ADC_WIDTH = ctpg_pkg::AdcWidthDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ctpg_evt_if.sink   evt_i,
  ctpg_res_if.source res_o,
  ctpg_cfg_if.sink   cfg_i
);

  ctpg_pkg::cfg_t       cfg;
  ctpg_pkg::evt_ctl_t   ctl;
  logic                 stg_valid;
  logic                 take;
  logic [ADC_WIDTH-1:0] sample;

  ctpg_cfg_regs u_cfg_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  ctpg_in_stage #(
    .ADC_WIDTH (ADC_WIDTH)
  ) u_in_stage (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .evt_i    (evt_i),
    .take_i   (take),
    .valid_o  (stg_valid),
    .ctl_o    (ctl),
    .sample_o (sample)
  );

  ctpg_core #(
    .ADC_WIDTH (ADC_WIDTH)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .valid_i  (stg_valid),
    .ctl_i    (ctl),
    .sample_i (sample),
    .take_o   (take),
    .res_o    (res_o)
  );

endmodule
